// ===== rtl/wrxaf_pkg.sv =====
// Shared constants and a helper for the receive-side address filter and deframer.
package wrxaf_pkg;

  // Configuration register indexes.
  localparam logic CfgMonitorKind   = 1'b0;
  localparam logic CfgFilterAddress = 1'b1;

  // Capture header kinds.
  localparam logic MonPrism    = 1'b0;
  localparam logic MonRadiotap = 1'b1;

  localparam logic [47:0] FilterAddressReset = 48'h1322_3344_5566;

  // Frame-control bits, little-endian word.
  localparam logic [15:0] FcTypeMask  = 16'h000C;
  localparam logic [15:0] FcTypeData  = 16'h0008;
  localparam int unsigned FcQosBit    = 7;
  localparam int unsigned FcToDsBit   = 8;
  localparam int unsigned FcFromDsBit = 9;
  localparam int unsigned FcProtBit   = 14;

  // 802.11 header lengths, in bytes.
  localparam logic [5:0] HdrLenBase  = 6'd24;
  localparam logic [5:0] HdrLenFourA = 6'd30;
  localparam logic [5:0] HdrLenQos   = 6'd2;
  localparam logic [5:0] HdrLenLlc   = 6'd8;

  // Header offsets and size limits.
  localparam logic [10:0] OffAddr1      = 11'd4;
  localparam logic [10:0] OffAddr1Last  = 11'd9;
  localparam logic [10:0] OffAddr3      = 11'd16;
  localparam logic [10:0] OffAddr3Last  = 11'd21;
  localparam logic [10:0] OffPayloadMin = 11'd32;
  localparam logic [15:0] MinAfterCap   = 16'd38;
  localparam logic [10:0] MinFrameLen   = 11'd14;

  // Picks octet idx of a MAC address, octet 0 being the first on air.
  function automatic logic [7:0] filter_octet(input logic [47:0] addr, input logic [2:0] idx);
    logic [7:0] res;
    unique case (idx)
      3'd0:    res = addr[47:40];
      3'd1:    res = addr[39:32];
      3'd2:    res = addr[31:24];
      3'd3:    res = addr[23:16];
      3'd4:    res = addr[15:8];
      3'd5:    res = addr[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/wifi_rx_address_filter_deframer.sv =====
// Receive-side 802.11 data frame deframer with destination address filter.

// The block takes one captured frame byte per cycle on the slave stream while it is ready,
// together with the frame length and an end-of-frame mark on tlast. It skips the capture header
// (a prism header of PRISM_LENGTH bytes, or a radiotap header whose little-endian length sits in
// bytes 2 and 3), reads the 802.11 header, and passes on the payload of unprotected data frames
// whose destination (address 3 when ToDS is set, address 1 otherwise) equals the filter address.
// Every request is handled in the cycle it is accepted, so the block sustains one byte per clock
// unless the output stalls; a payload byte appears on the master stream in the cycle after its
// input byte. The output register is the only stage: a new byte is taken whenever that register
// is empty or being drained in the same cycle. Short frames produce no output. Configuration
// writes take effect from the next byte on.
module wifi_rx_address_filter_deframer #(
  parameter int unsigned PRISM_LENGTH        = 144,
  parameter int unsigned RADIOTAP_MIN_LENGTH = 8,
  parameter int unsigned MAX_FRAME_BYTES     = 2000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // rx_byte [7:0], frame_length [18:8], zeros above
  input  logic        s_axis_tlast,  // end_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // payload_byte [7:0]
  output logic        m_axis_tlast,  // payload_last
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  import wrxaf_pkg::*;

  localparam logic [15:0] PrismLen = 16'(PRISM_LENGTH);
  localparam logic [15:0] RtapMin  = 16'(RADIOTAP_MIN_LENGTH);
  localparam logic [12:0] MaxBytes = 13'(MAX_FRAME_BYTES);

  // Configuration registers.
  logic        mon_kind_q;
  logic [47:0] filt_q;

  // Per-frame state.
  logic [10:0] pos_q, pos_d;
  logic [15:0] cap_len_q, cap_len_d;
  logic [15:0] fc_q, fc_d;
  logic [5:0]  hdr_len_q, hdr_len_d;
  logic        m1_q, m1_d;
  logic        m3_q, m3_d;
  logic        rej_q, rej_d;
  logic [7:0]  head_q [3];

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic        in_fire;
  logic [7:0]  rx_b;
  logic        eof;
  logic [10:0] len_c;
  logic [15:0] mon;
  logic [15:0] pos16;
  logic [15:0] off16;
  logic [10:0] off;
  logic        main_en;
  logic        early_en;
  logic [1:0]  early_l;
  logic        lo_en, hi_en;
  logic [7:0]  lo_byte, hi_byte;
  logic [7:0]  fc_lo;
  logic [15:0] fc_new;
  logic [5:0]  hdr_base;
  logic [10:0] a1_diff, a3_diff;
  logic        len_ok;
  logic        dest_ok;
  logic        emit;
  logic        last_c;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign rx_b          = s_axis_tdata[7:0];
  assign eof           = s_axis_tlast;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    // The capture buffer caps the length.
    if ({2'b00, s_axis_tdata[18:8]} > MaxBytes) begin
      len_c = MaxBytes[10:0];
    end else begin
      len_c = s_axis_tdata[18:8];
    end

    // Radiotap length arrives little-endian in bytes 2 and 3.
    cap_len_d = cap_len_q;
    if (mon_kind_q == MonRadiotap && pos_q == 11'd2) begin
      cap_len_d = {8'h00, rx_b};
    end else if (mon_kind_q == MonRadiotap && pos_q == 11'd3) begin
      cap_len_d = {rx_b, cap_len_q[7:0]};
    end

    mon   = (mon_kind_q == MonRadiotap) ? cap_len_d : PrismLen;
    pos16 = {5'd0, pos_q};
    off16 = pos16 - mon;
    off   = off16[10:0];

    main_en = (mon_kind_q == MonPrism || pos_q > 11'd3) && pos16 >= mon
              && pos_q < len_c;

    // A radiotap length below four places the start of the 802.11 header in bytes
    // already seen; replay them from the head register once the length is known.
    early_en = mon_kind_q == MonRadiotap && pos_q == 11'd3 && cap_len_d <= 16'd3;
    early_l  = cap_len_d[1:0];

    lo_en   = 1'b0;
    hi_en   = 1'b0;
    lo_byte = rx_b;
    hi_byte = rx_b;
    if (early_en) begin
      lo_en = 1'b1;
      hi_en = early_l != 2'd3;
      unique case (early_l)
        2'd0: begin
          lo_byte = head_q[0];
          hi_byte = head_q[1];
        end
        2'd1: begin
          lo_byte = head_q[1];
          hi_byte = head_q[2];
        end
        2'd2: begin
          lo_byte = head_q[2];
          hi_byte = rx_b;
        end
        default: begin
          lo_byte = rx_b;
          hi_byte = rx_b;
        end
      endcase
    end else if (main_en) begin
      lo_en = off == 11'd0;
      hi_en = off == 11'd1;
    end

    fc_lo  = lo_en ? lo_byte : fc_q[7:0];
    fc_new = hi_en ? {hi_byte, fc_lo} : {fc_q[15:8], fc_lo};
    fc_d   = fc_new;

    hdr_base = (fc_new[FcToDsBit] && fc_new[FcFromDsBit]) ? HdrLenFourA : HdrLenBase;
    hdr_len_d = hdr_len_q;
    rej_d     = rej_q;
    if (hi_en) begin
      hdr_len_d = hdr_base + (fc_new[FcQosBit] ? HdrLenQos : 6'd0) + HdrLenLlc;
      if ((fc_new & FcTypeMask) != FcTypeData || fc_new[FcProtBit]) begin
        rej_d = 1'b1;
      end
    end

    // Destination address compares, one octet per byte.
    a1_diff = off - OffAddr1;
    a3_diff = off - OffAddr3;
    m1_d = m1_q;
    m3_d = m3_q;
    if (main_en && off >= OffAddr1 && off <= OffAddr1Last
        && rx_b != filter_octet(filt_q, a1_diff[2:0])) begin
      m1_d = 1'b0;
    end
    if (main_en && off >= OffAddr3 && off <= OffAddr3Last
        && rx_b != filter_octet(filt_q, a3_diff[2:0])) begin
      m3_d = 1'b0;
    end

    // Frame size checks; main_en guarantees the length exceeds the capture header.
    len_ok = len_c >= MinFrameLen && ({5'd0, len_c} - mon) > MinAfterCap;
    if (mon_kind_q == MonPrism) begin
      len_ok = len_ok && {5'd0, len_c} > PrismLen;
    end else begin
      len_ok = len_ok && {5'd0, len_c} > RtapMin && {5'd0, len_c} > cap_len_d;
    end
    dest_ok = fc_q[FcToDsBit] ? m3_q : m1_q;

    emit = main_en && off >= OffPayloadMin && off >= {5'd0, hdr_len_q} && !rej_q
           && len_ok && dest_ok;
    last_c = eof || ({1'b0, pos_q} + 12'd1) == {1'b0, len_c};

    pos_d = (pos_q == '1) ? pos_q : pos_q + 11'd1;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_kind_q <= MonRadiotap;
      filt_q     <= FilterAddressReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMonitorKind:   mon_kind_q <= cfg_data_i[0];
        CfgFilterAddress: filt_q     <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Frame state; everything returns to its start value after the end-of-frame byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cap_len_q <= '0;
      fc_q      <= '0;
      hdr_len_q <= '0;
      m1_q      <= 1'b1;
      m3_q      <= 1'b1;
      rej_q     <= 1'b0;
    end else if (in_fire) begin
      if (eof) begin
        pos_q     <= '0;
        cap_len_q <= '0;
        fc_q      <= '0;
        hdr_len_q <= '0;
        m1_q      <= 1'b1;
        m3_q      <= 1'b1;
        rej_q     <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        cap_len_q <= cap_len_d;
        fc_q      <= fc_d;
        hdr_len_q <= hdr_len_d;
        m1_q      <= m1_d;
        m3_q      <= m3_d;
        rej_q     <= rej_d;
      end
    end
  end

  // The first three capture bytes are kept for the short radiotap case.
  always_ff @(posedge clk_i) begin
    if (in_fire && pos_q < 11'd3) begin
      head_q[pos_q[1:0]] <= rx_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_byte_q <= rx_b;
      out_last_q <= last_c;
    end
  end

endmodule

// ===== rtl/wrxaf_checker.sv =====
// Port-level checks for the receive-side address filter and deframer.
module wrxaf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A result waiting for the sink is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // An empty output stage always takes a new request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // A full, stalled output stage refuses new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output is stalled");

  // A new result only follows an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without a request");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind wifi_rx_address_filter_deframer wrxaf_checker u_wrxaf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/tb.sv =====
// Testbench for the receive-side 802.11 address filter and deframer.
`timescale 1ns / 1ps

module tb;
  import wrxaf_pkg::*;

  // Block sizes, matching the instance below.
  localparam int PRISM_LEN    = 144;
  localparam int RADIOTAP_MIN = 8;
  localparam int MAX_FRAME    = 2000;

  // Frame-control layout, little-endian word.
  localparam logic [15:0] FC_TYPE_MASK = 16'h000C;
  localparam logic [15:0] FC_TYPE_DATA = 16'h0008;
  localparam logic [15:0] FC_PROT_MASK = 16'h4000;
  localparam int FC_QOS_BIT    = 7;
  localparam int FC_TODS_BIT   = 8;
  localparam int FC_FROMDS_BIT = 9;

  localparam logic [47:0] MAC_AT_RESET = 48'h1322_3344_5566;

  // Cycles allowed for the output register to settle before a register write.
  localparam int SETTLE_CYCLES = 8;
  // Cycles without any accepted request before the run is declared hung.
  localparam int QUIET_LIMIT   = 2000;

  typedef struct packed {
    logic [7:0]  data;
    logic [10:0] flen;
    logic        eof;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_t;

  typedef enum int {SinkOpen, SinkCoin, SinkPulse, SinkHiccup} sink_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // rx_byte [7:0], frame_length [18:8], zeros above
  logic        s_axis_tlast = 1'b0;  // end_of_frame
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // payload_byte [7:0]
  logic        m_axis_tlast;  // payload_last
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [47:0] cfg_data_i = '0;

  // Bytes waiting to be sent, and payload bytes predicted but not yet seen.
  rx_item_t rx_bytes_q [$];
  payload_t payload_q [$];
  rx_item_t on_bus;
  int       bytes_queued = 0;
  int       bytes_taken = 0;
  int       payload_faults = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       quiet_cycles = 0;
  sink_mode_e sink_mode = SinkOpen;
  int       sink_span = 0;
  int       sink_tick = 0;

  // Deframer state as the block should hold it; cleared after every end-of-frame byte.
  logic        cfg_kind = MonRadiotap;
  logic [47:0] cfg_addr = MAC_AT_RESET;
  logic [10:0] rx_pos;
  logic [15:0] cap_hdr_len;
  logic [15:0] fc_word;
  logic [5:0]  mac_hdr_len;
  logic        addr1_hit;
  logic        addr3_hit;
  logic        frame_drop;
  logic [7:0]  head_q [4];

  wifi_rx_address_filter_deframer #(
    .PRISM_LENGTH       (PRISM_LEN),
    .RADIOTAP_MIN_LENGTH(RADIOTAP_MIN),
    .MAX_FRAME_BYTES    (MAX_FRAME)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic reset_frame_state();
    rx_pos = '0;
    cap_hdr_len = '0;
    fc_word = '0;
    mac_hdr_len = '0;
    addr1_hit = 1'b1;
    addr3_hit = 1'b1;
    frame_drop = 1'b0;
    head_q = '{default: 8'h00};
  endtask

  // One byte at offset off into the 802.11 header: frame control, then the two addresses.
  task automatic header_byte(input int off, input logic [7:0] b);
    logic [15:0] fc;
    int hl;
    if (off == 0) begin
      fc_word[7:0] = b;
    end else if (off == 1) begin
      fc = {b, fc_word[7:0]};
      fc_word = fc;
      hl = (fc[FC_TODS_BIT] && fc[FC_FROMDS_BIT]) ? 30 : 24;
      if (fc[FC_QOS_BIT]) hl += 2;
      mac_hdr_len = 6'(hl + 8);
      if ((fc & FC_TYPE_MASK) != FC_TYPE_DATA || (fc & FC_PROT_MASK) != 0) frame_drop = 1'b1;
    end else if (off >= 4 && off <= 9) begin
      if (b != cfg_addr[8 * (9 - off) +: 8]) addr1_hit = 1'b0;
    end else if (off >= 16 && off <= 21) begin
      if (b != cfg_addr[8 * (21 - off) +: 8]) addr3_hit = 1'b0;
    end
  endtask

  // Works out what one accepted byte yields and queues the payload byte, if any.
  task automatic deframe_byte(input logic [7:0] b, input logic [10:0] flen, input logic eof);
    int len, pos, mon, off, k;
    logic ok, dest;
    len = (flen > MAX_FRAME) ? MAX_FRAME : int'(flen);
    pos = rx_pos;
    if (pos < 4) head_q[pos] = b;
    if (cfg_kind == MonRadiotap && pos == 2) begin
      cap_hdr_len = {8'h00, b};
    end else if (cfg_kind == MonRadiotap && pos == 3) begin
      cap_hdr_len = {b, cap_hdr_len[7:0]};
      // A radiotap length under four puts the 802.11 header on bytes already seen.
      for (k = cap_hdr_len; k <= 3; k++) header_byte(k - int'(cap_hdr_len), head_q[k]);
    end
    mon = (cfg_kind == MonRadiotap) ? int'(cap_hdr_len) : PRISM_LEN;
    if ((cfg_kind == MonPrism || pos > 3) && pos >= mon && pos < len) begin
      off = pos - mon;
      header_byte(off, b);
      if (off >= 32 && off >= mac_hdr_len && !frame_drop) begin
        dest = fc_word[FC_TODS_BIT] ? addr3_hit : addr1_hit;
        ok = len >= 14 && dest && (len - mon) > 38;
        if (cfg_kind == MonPrism) ok = ok && len > PRISM_LEN;
        else ok = ok && len > RADIOTAP_MIN && len > int'(cap_hdr_len);
        if (ok) payload_q.push_back(payload_t'{b, eof || pos + 1 == len});
      end
    end
    if (eof) reset_frame_state();
    else if (rx_pos != 11'h7FF) rx_pos++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic [10:0] flen, input logic eof);
    rx_bytes_q.push_back(rx_item_t'{b, flen, eof});
    bytes_queued++;
  endtask

  // The filter address with one octet spoiled, so that it never matches.
  function automatic logic [47:0] decoy_mac();
    logic [47:0] flip;
    flip = 48'($urandom_range(1, 255)) << (8 * $urandom_range(0, 5));
    return cfg_addr ^ flip;
  endfunction

  // Queues one frame: capture header, 802.11 header, pay_len payload bytes. len_delta skews
  // the length field against the bytes sent; a nonzero cut below the frame size ends it early.
  task automatic queue_frame(input int cap_len, input logic [15:0] fc, input bit hit,
                             input int pay_len, input int len_delta, input int cut);
    logic [7:0] frm [$];
    logic [47:0] a1, a3;
    int base, hdr, total, flen, n, i;
    base = (cfg_kind == MonPrism) ? PRISM_LEN : cap_len;
    hdr = ((fc[FC_TODS_BIT] && fc[FC_FROMDS_BIT]) ? 30 : 24) + (fc[FC_QOS_BIT] ? 2 : 0) + 8;
    total = base + hdr + pay_len;
    for (i = 0; i < total; i++) frm.push_back(8'($urandom));
    a1 = ($urandom_range(0, 1) != 0) ? cfg_addr : decoy_mac();
    a3 = ($urandom_range(0, 1) != 0) ? cfg_addr : decoy_mac();
    if (fc[FC_TODS_BIT]) a3 = hit ? cfg_addr : decoy_mac();
    else a1 = hit ? cfg_addr : decoy_mac();
    frm[base] = fc[7:0];
    frm[base + 1] = fc[15:8];
    for (i = 0; i < 6; i++) begin
      frm[base + 4 + i] = a1[8 * (5 - i) +: 8];
      frm[base + 16 + i] = a3[8 * (5 - i) +: 8];
    end
    // The radiotap length wins where a tiny header overlaps the 802.11 header.
    if (cfg_kind == MonRadiotap) begin
      frm[2] = cap_len[7:0];
      frm[3] = cap_len[15:8];
    end
    flen = total + len_delta;
    if (flen < 0) flen = 0;
    if (flen > 2047) flen = 2047;
    n = (cut > 0 && cut < total) ? cut : total;
    for (i = 0; i < n; i++) push_byte(frm[i], 11'(flen), i == n - 1);
  endtask

  // Unstructured bytes; a wobbling length changes from byte to byte.
  task automatic queue_noise(input int n, input logic [10:0] flen, input bit wobble);
    int i;
    for (i = 0; i < n; i++) push_byte(8'($urandom), wobble ? 11'($urandom) : flen, i == n - 1);
  endtask

  task automatic random_item();
    int cap, pay, delta, cut, pick;
    logic [15:0] fc;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      queue_noise($urandom_range(1, 48), 11'($urandom), $urandom_range(0, 1));
      return;
    end
    cap = $urandom_range(8, 40);
    if (pick < 14) cap = $urandom_range(0, 3);
    else if (pick < 18) cap = $urandom_range(4, 7);
    // Mostly unprotected data frames with random flags; sometimes any frame control at all.
    fc = FC_TYPE_DATA | (16'($urandom) & 16'hBFF3);
    if ($urandom_range(0, 7) == 0) fc = 16'($urandom);
    pay = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
    delta = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) - 10 : 0;
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 200) : 0;
    queue_frame(cap, fc, $urandom_range(0, 3) != 0, pay, delta, cut);
  endtask

  // Holds the sender until every queued byte is taken and every payload byte has come out.
  task automatic await_drain();
    do @(posedge clk_i);
    while (bytes_taken != bytes_queued || payload_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both registers are written back to back on an idle block.
  task automatic write_config(input logic kind, input logic [47:0] mac);
    await_drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgMonitorKind;
    cfg_data_i <= 48'(kind);
    @(posedge clk_i);
    cfg_index_i <= CfgFilterAddress;
    cfg_data_i <= mac;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_kind = kind;
    cfg_addr = mac;
  endtask

  // Sender: one request per cycle in bursts while the block is ready, with gaps in between.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(on_bus.data, on_bus.flen, on_bus.eof);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          on_bus = rx_bytes_q.pop_front();
          s_axis_tdata <= {5'b0, on_bus.flen, on_bus.data};
          s_axis_tlast <= on_bus.eof;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // Receiver: checks every payload byte against the oldest prediction and stalls
  // in stretches of changing character.
  always @(posedge clk_i) begin
    payload_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (payload_q.size() == 0) begin
          payload_faults++;
          if (payload_faults <= 10)
            $display("[%0t] unexpected payload byte %02h last %0b",
                     $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = payload_q.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
            payload_faults++;
            if (payload_faults <= 10)
              $display("[%0t] payload mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                       $time, want.data, m_axis_tdata, want.last, m_axis_tlast);
          end
        end
      end
      if (sink_span == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        sink_span = $urandom_range(16, 256);
      end else begin
        sink_span--;
      end
      sink_tick++;
      case (sink_mode)
        SinkOpen:  m_axis_tready <= 1'b1;
        SinkCoin:  m_axis_tready <= ($urandom_range(0, 9) < 6);
        SinkPulse: m_axis_tready <= (sink_tick % 5 == 0);
        default:   m_axis_tready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // Watchdog: a hung block shows as a long run of cycles with no request on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_frame_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Radiotap with the filter address as it comes out of reset.
    queue_frame(8, 16'h0008, 1, 8, 0, 0);      // plain data frame
    queue_frame(12, 16'h0108, 1, 8, 0, 0);     // ToDS: destination is address 3
    queue_frame(8, 16'h0388, 1, 4, 0, 0);      // four addresses with QoS
    queue_frame(8, 16'h0388, 1, 0, 0, 0);      // nothing after the header
    queue_frame(8, 16'h4008, 1, 8, 0, 0);      // protected frame
    queue_frame(8, 16'h0008, 0, 8, 0, 0);      // destination misses
    queue_frame(8, 16'h0008, 1, 6, 0, 0);      // exactly 38 bytes after the capture header
    queue_noise(12, 11'd12, 0);                // shorter than 14
    queue_frame(0, 16'h0008, 1, 8, 0, 0);      // tiny radiotap lengths
    queue_frame(1, 16'h0008, 1, 8, 0, 0);
    queue_frame(2, 16'h0008, 1, 8, 0, 0);
    queue_frame(3, 16'h0008, 1, 8, 0, 0);
    queue_frame(8, 16'h0008, 1, 12, 7, 0);     // end mark before the length runs out
    queue_frame(8, 16'h0008, 1, 12, 1990, 0);  // length field above the capture buffer
    await_drain();

    write_config(MonPrism, 48'h0);
    queue_frame(0, 16'h0108, 1, 8, 0, 0);

    write_config(MonRadiotap, 48'({$urandom, $urandom}));
    while (bytes_queued - bytes_taken < 80) random_item();

    await_drain();
    if (payload_faults == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== wifi_rx_address_filter_deframer.f =====
rtl/wrxaf_pkg.sv
rtl/wifi_rx_address_filter_deframer.sv
rtl/wrxaf_checker.sv
tb/sv/tb.sv
